### rtl/translated_block_map_core_defines.svh
// ----------------------------------------------------------------------------
// translated block map core assertion macros
// shared assertion shorthands, clocked on clk_i and disabled in reset
// ----------------------------------------------------------------------------
`ifndef TRANSLATED_BLOCK_MAP_CORE_DEFINES_SVH
`define TRANSLATED_BLOCK_MAP_CORE_DEFINES_SVH

// property must hold at every clock edge out of reset
`define TBM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition must never be seen
`define TBM_ASSERT_NEVER(lbl, cond, msg) \
  `TBM_ASSERT(lbl, !(cond), msg)

`endif

### rtl/tbm_pkg.sv
// ----------------------------------------------------------------------------
// tbm_pkg
// constants and codes for the translated block map core
// ----------------------------------------------------------------------------
package tbm_pkg;

  localparam int unsigned SLOTS_DEF       = 1024;
  localparam int unsigned OFFSET_BITS_DEF = 20;

  localparam int unsigned FUNC_W   = 3;
  localparam int unsigned PC_W     = 32;
  localparam int unsigned EMIT_W   = 12;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned CFG_W    = 21;
  localparam int unsigned S_DATA_W = ((PC_W + EMIT_W + 7) / 8) * 8;

  localparam int unsigned CFG_RESET   = 1048576;
  localparam int unsigned FREE_NEEDED = 512;
  localparam int unsigned HASH_SH_LO  = 1;
  localparam int unsigned HASH_SH_HI  = HASH_SH_LO + 13;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOOKUP  = 3'd0,
    FUNC_BEGIN   = 3'd1,
    FUNC_ADVANCE = 3'd2,
    FUNC_FLUSH   = 3'd3,
    FUNC_RESET   = 3'd4
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK   = 2'd0,
    STATUS_MISS = 2'd1,
    STATUS_FULL = 2'd2,
    STATUS_LOW  = 2'd3
  } status_e;

endpackage

### rtl/translated_block_map_core.sv
// ----------------------------------------------------------------------------
// translated block map core
// open-addressed pc to code offset map with linear probing in one slot ram
// ----------------------------------------------------------------------------
// Commands enter on the s_axis channel (tuser: func, tdata: guest_pc then
// emitted_count) and each gives one result beat on m_axis (tuser: status,
// tdata: entry_offset then flush_needed). cfg_we_i writes the code region
// size in halfwords at any idle clock edge.
// Lookup and begin hash the pc, then probe the slot ram one slot per cycle
// through a single read port with registered data: ST_ISSUE starts the
// read, ST_PROBE checks P slots (1 to SLOTS), the result is ready in
// ST_RESP and the next beat is taken once the core is back in ST_IDLE;
// a slot count that is not a power of two adds shift-subtract hashing in
// ST_HASH before ST_ISSUE. Advance, flush, reset, refused begins and unused
// function codes go from the beat straight to ST_RESP. One command is in
// flight at a time.
// The result sits in an output register; a stalled receiver holds it there
// while the next command is already taken and worked on, and a finished
// result waits in the core until the output register is free.
// After rst_ni and after a reset command the slot ram is cleared one slot
// per cycle, with s_axis_tready low; configuration writes are still taken.
// The region size resets to 1048576 halfwords.
// ----------------------------------------------------------------------------
`include "translated_block_map_core_defines.svh"

module translated_block_map_core #(
  parameter int unsigned SLOTS       = tbm_pkg::SLOTS_DEF,
  parameter int unsigned OFFSET_BITS = tbm_pkg::OFFSET_BITS_DEF,
  localparam int unsigned M_DATA_W   = ((OFFSET_BITS + 1 + 7) / 8) * 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tbm_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [tbm_pkg::S_DATA_W-1:0]  s_axis_tdata,  // guest_pc, emitted_count
  input  logic [tbm_pkg::FUNC_W-1:0]    s_axis_tuser,  // func
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [M_DATA_W-1:0]           m_axis_tdata,  // entry_offset, flush_needed
  output logic [tbm_pkg::STATUS_W-1:0]  m_axis_tuser   // status
);

  localparam int unsigned PC_W   = tbm_pkg::PC_W;
  localparam int unsigned EMIT_W = tbm_pkg::EMIT_W;
  localparam int unsigned CFG_W  = tbm_pkg::CFG_W;
  localparam int unsigned IDX_W  = $clog2(SLOTS);
  localparam int unsigned CNT_W  = $clog2(SLOTS + 1);
  localparam int unsigned POS_W  = OFFSET_BITS + 1;
  localparam int unsigned ENT_W  = 1 + PC_W + OFFSET_BITS;
  localparam int unsigned FULL_LIMIT = SLOTS * 3 / 4;
  localparam bit          IS_POW2    = (SLOTS & (SLOTS - 1)) == 0;
  localparam int unsigned KMAX   = PC_W - IDX_W;
  localparam int unsigned K_W    = $clog2(KMAX + 1);
  localparam int unsigned DIV_W  = PC_W + 1;
  localparam int unsigned CMP_W  = (CFG_W > POS_W) ? CFG_W : POS_W;
  localparam int unsigned ADV_W  = ((POS_W > EMIT_W) ? POS_W : EMIT_W) + 1;
  localparam logic [CMP_W-1:0] CAP = CMP_W'(1) << OFFSET_BITS;
  localparam logic [CMP_W-1:0] CFG_RST = CMP_W'(tbm_pkg::CFG_RESET);
  localparam logic [POS_W-1:0] LIMIT_RESET = POS_W'((CFG_RST < CAP) ? CFG_RST : CAP);
  localparam logic [DIV_W-1:0] DIV_INIT = DIV_W'(SLOTS) << KMAX;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SLOTS - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HASH,
    ST_ISSUE,
    ST_PROBE,
    ST_RESP,
    ST_CLEAR
  } state_e;

  state_e                   state_q;
  tbm_pkg::func_e           op_q;
  logic [PC_W-1:0]          pc_q;
  logic [IDX_W-1:0]         idx_q;
  logic [IDX_W-1:0]         n_q;
  logic [PC_W-1:0]          rem_q;
  logic [DIV_W-1:0]         div_q;
  logic [K_W-1:0]           k_q;
  logic [CNT_W-1:0]         used_cnt_q;
  logic [POS_W-1:0]         pos_q;
  logic [POS_W-1:0]         limit_q;
  logic                     dirty_q;
  logic                     clr_after_q;
  tbm_pkg::status_e         res_status_q;
  logic [OFFSET_BITS-1:0]   res_offset_q;
  logic                     res_flush_q;
  logic                     m_valid_q;
  tbm_pkg::status_e         m_status_q;
  logic [OFFSET_BITS-1:0]   m_offset_q;
  logic                     m_flush_q;

  logic [ENT_W-1:0]         mem_q [SLOTS];
  logic [ENT_W-1:0]         rd_q;

  tbm_pkg::func_e           s_func;
  logic [PC_W-1:0]          pc_in;
  logic [EMIT_W-1:0]        emit_in;
  logic [PC_W-1:0]          hash;
  logic                     s_acc;
  logic                     out_free;
  logic                     rd_used;
  logic [PC_W-1:0]          rd_pc;
  logic [OFFSET_BITS-1:0]   rd_off;
  logic                     probe_stop;
  logic                     last_probe;
  logic [IDX_W-1:0]         idx_nxt;
  logic [POS_W-1:0]         pos_pad;
  logic                     space_low;
  logic                     table_full;
  logic [ADV_W-1:0]         adv_sum;
  logic [POS_W-1:0]         adv_pos;
  logic [CMP_W-1:0]         cfg_ext;
  logic [POS_W-1:0]         cfg_limit;
  logic                     rem_ge;
  logic [PC_W-1:0]          rem_sub;
  state_e                   hash_state;
  logic                     mem_we;
  logic [ENT_W-1:0]         mem_wdata;
  logic [IDX_W-1:0]         mem_raddr;

  assign s_func  = tbm_pkg::func_e'(s_axis_tuser);
  assign pc_in   = s_axis_tdata[PC_W-1:0];
  assign emit_in = s_axis_tdata[PC_W +: EMIT_W];
  assign hash    = (pc_in >> tbm_pkg::HASH_SH_LO) ^ (pc_in >> tbm_pkg::HASH_SH_HI);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;

  assign rd_used    = rd_q[ENT_W-1];
  assign rd_pc      = rd_q[OFFSET_BITS +: PC_W];
  assign rd_off     = rd_q[OFFSET_BITS-1:0];
  assign probe_stop = !rd_used || (rd_pc == pc_q);
  assign last_probe = (n_q == IDX_LAST);
  assign idx_nxt    = (idx_q == IDX_LAST) ? '0 : idx_q + 1'b1;

  assign pos_pad    = pos_q + POS_W'(pos_q[0]);
  assign space_low  = ((POS_W + 1)'(pos_q) + (POS_W + 1)'(tbm_pkg::FREE_NEEDED))
                      > (POS_W + 1)'(limit_q);
  assign table_full = used_cnt_q > CNT_W'(FULL_LIMIT);
  assign adv_sum    = ADV_W'(pos_q) + ADV_W'(emit_in);
  assign adv_pos    = (adv_sum < ADV_W'(limit_q)) ? POS_W'(adv_sum) : limit_q;

  assign cfg_ext   = CMP_W'(cfg_wdata_i);
  assign cfg_limit = POS_W'((cfg_ext < CAP) ? cfg_ext : CAP);

  // restoring reduction of the hash by the slot count
  assign rem_ge     = DIV_W'(rem_q) >= div_q;
  assign rem_sub    = rem_ge ? PC_W'(DIV_W'(rem_q) - div_q) : rem_q;
  assign hash_state = IS_POW2 ? ST_ISSUE : ST_HASH;

  assign mem_we    = (state_q == ST_CLEAR) ||
                     (state_q == ST_PROBE && op_q == tbm_pkg::FUNC_BEGIN && probe_stop);
  assign mem_wdata = (state_q == ST_CLEAR) ? '0 :
                     {1'b1, pc_q, pos_pad[OFFSET_BITS-1:0]};
  assign mem_raddr = (state_q == ST_PROBE) ? idx_nxt : idx_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[idx_q] <= mem_wdata;
    end
    rd_q <= mem_q[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      op_q         <= tbm_pkg::FUNC_LOOKUP;
      pc_q         <= '0;
      idx_q        <= '0;
      n_q          <= '0;
      rem_q        <= '0;
      div_q        <= '0;
      k_q          <= '0;
      used_cnt_q   <= '0;
      pos_q        <= '0;
      limit_q      <= LIMIT_RESET;
      dirty_q      <= 1'b0;
      clr_after_q  <= 1'b0;
      res_status_q <= tbm_pkg::STATUS_OK;
      res_offset_q <= '0;
      res_flush_q  <= 1'b0;
      m_valid_q    <= 1'b0;
      m_status_q   <= tbm_pkg::STATUS_OK;
      m_offset_q   <= '0;
      m_flush_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_limit;
      end
      if (state_q == ST_RESP && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_valid_q && m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (s_acc) begin
            op_q         <= s_func;
            pc_q         <= pc_in;
            n_q          <= '0;
            idx_q        <= hash[IDX_W-1:0];
            rem_q        <= hash;
            div_q        <= DIV_INIT;
            k_q          <= K_W'(KMAX);
            res_offset_q <= '0;
            res_flush_q  <= (s_func == tbm_pkg::FUNC_FLUSH) && dirty_q;
            clr_after_q  <= (s_func == tbm_pkg::FUNC_RESET);
            case (s_func)
              tbm_pkg::FUNC_LOOKUP: begin
                res_status_q <= tbm_pkg::STATUS_OK;
                state_q      <= hash_state;
              end
              tbm_pkg::FUNC_BEGIN: begin
                if (table_full) begin
                  res_status_q <= tbm_pkg::STATUS_FULL;
                  state_q      <= ST_RESP;
                end else if (space_low) begin
                  res_status_q <= tbm_pkg::STATUS_LOW;
                  state_q      <= ST_RESP;
                end else begin
                  res_status_q <= tbm_pkg::STATUS_OK;
                  state_q      <= hash_state;
                end
              end
              tbm_pkg::FUNC_ADVANCE: begin
                res_status_q <= tbm_pkg::STATUS_OK;
                pos_q        <= adv_pos;
                state_q      <= ST_RESP;
              end
              tbm_pkg::FUNC_FLUSH: begin
                res_status_q <= tbm_pkg::STATUS_OK;
                dirty_q      <= 1'b0;
                state_q      <= ST_RESP;
              end
              tbm_pkg::FUNC_RESET: begin
                res_status_q <= tbm_pkg::STATUS_OK;
                used_cnt_q   <= '0;
                pos_q        <= '0;
                dirty_q      <= 1'b0;
                state_q      <= ST_RESP;
              end
              default: begin
                res_status_q <= tbm_pkg::STATUS_OK;
                state_q      <= ST_RESP;
              end
            endcase
          end
        end
        ST_HASH: begin
          rem_q <= rem_sub;
          div_q <= div_q >> 1;
          k_q   <= k_q - 1'b1;
          if (k_q == '0) begin
            idx_q   <= rem_sub[IDX_W-1:0];
            state_q <= ST_ISSUE;
          end
        end
        ST_ISSUE: begin
          state_q <= ST_PROBE;
        end
        ST_PROBE: begin
          if (probe_stop) begin
            state_q <= ST_RESP;
            if (op_q == tbm_pkg::FUNC_BEGIN) begin
              if (!rd_used) begin
                used_cnt_q <= used_cnt_q + 1'b1;
              end
              pos_q        <= pos_pad;
              dirty_q      <= 1'b1;
              res_status_q <= tbm_pkg::STATUS_OK;
              res_offset_q <= pos_pad[OFFSET_BITS-1:0];
            end else if (rd_used) begin
              res_status_q <= tbm_pkg::STATUS_OK;
              res_offset_q <= rd_off;
            end else begin
              res_status_q <= tbm_pkg::STATUS_MISS;
            end
          end else if (last_probe) begin
            state_q      <= ST_RESP;
            res_status_q <= (op_q == tbm_pkg::FUNC_BEGIN) ? tbm_pkg::STATUS_FULL
                                                          : tbm_pkg::STATUS_MISS;
          end else begin
            idx_q <= idx_nxt;
            n_q   <= n_q + 1'b1;
          end
        end
        ST_RESP: begin
          if (out_free) begin
            m_status_q <= res_status_q;
            m_offset_q <= res_offset_q;
            m_flush_q  <= res_flush_q;
            idx_q      <= '0;
            state_q    <= clr_after_q ? ST_CLEAR : ST_IDLE;
          end
        end
        ST_CLEAR: begin
          idx_q <= idx_nxt;
          if (idx_q == IDX_LAST) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_status_q;
  assign m_axis_tdata  = M_DATA_W'({m_flush_q, m_offset_q});

  `TBM_ASSERT_NEVER(a_cnt_bound, used_cnt_q > CNT_W'(SLOTS), "slot count above table size")
  `TBM_ASSERT(a_cnt_step,
    (used_cnt_q != $past(used_cnt_q)) |->
      (used_cnt_q == $past(used_cnt_q) + 1'b1 || used_cnt_q == '0),
    "slot count moved by more than one")
  `TBM_ASSERT(a_one_beat, s_acc |=> !s_axis_tready, "second beat taken while busy")
  `TBM_ASSERT(a_insert_done,
    (state_q == ST_PROBE && mem_we) |=> (state_q == ST_RESP),
    "probe went on after insert")

endmodule

### dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// translated block map core testbench
// drives lookup, begin, advance, flush and reset commands and unused function codes
// with random gaps on both stream sides and checks every result beat against a
// predictor of the hashed pc map, across several code region sizes
// ----------------------------------------------------------------------------
module tb_top;
  import tbm_pkg::*;

  localparam int unsigned OFS_W            = OFFSET_BITS_DEF;
  localparam int unsigned OUT_W            = ((OFS_W + 1 + 7) / 8) * 8;
  localparam int unsigned FUNC_SPARE_FIRST = 5;
  localparam int unsigned FUNC_CODES       = 1 << FUNC_W;
  localparam int unsigned REPORT_MAX       = 10;
  localparam int unsigned HOLD_AT          = 700;
  localparam int unsigned HOLD_CYCLES      = 400;
  localparam int unsigned SETTLE_CYCLES    = 8;
  localparam int unsigned TAIL_CYCLES      = 100;
  localparam logic [31:0] SAME_HOME_MASK   = 32'hFF00_3800;
  localparam logic [CFG_W-1:0] REGION_MAX  = '1;

  typedef struct packed {
    status_e          status;
    logic [OFS_W-1:0] offset;
    logic             flush;
  } map_result_t;

  class offset_map_scoreboard;
    logic [PC_W-1:0]  pc_of     [SLOTS_DEF];
    logic [OFS_W-1:0] offset_of [SLOTS_DEF];
    bit               used      [SLOTS_DEF];
    int unsigned      occupied;
    int unsigned      position;
    int unsigned      region_hw;
    bit               dirty;
    map_result_t      due[$];
    int unsigned      errors;

    function new();
      clear_map();
      region_hw = CFG_RESET;
      errors    = 0;
    endfunction

    function void clear_map();
      foreach (used[i]) used[i] = 1'b0;
      occupied = 0;
      position = 0;
      dirty    = 1'b0;
    endfunction

    function void set_region(int unsigned hw);
      region_hw = hw;
    endfunction

    function int unsigned home(logic [PC_W-1:0] pc);
      return ((pc >> HASH_SH_LO) ^ (pc >> HASH_SH_HI)) % SLOTS_DEF;
    endfunction

    function void note_error(string msg);
      errors++;
      if (errors <= REPORT_MAX) $display("%s", msg);
    endfunction

    function void take_command(logic [FUNC_W-1:0] op, logic [PC_W-1:0] pc,
                               logic [EMIT_W-1:0] em);
      map_result_t r;
      int unsigned lim, idx, free_hw, pos, np;
      r.status = STATUS_OK;
      r.offset = '0;
      r.flush  = 1'b0;
      lim = (region_hw < (1 << OFS_W)) ? region_hw : (1 << OFS_W);
      case (op)
        FUNC_LOOKUP: begin
          r.status = STATUS_MISS;
          idx = home(pc);
          for (int n = 0; n < SLOTS_DEF; n++) begin
            if (!used[idx]) break;
            if (pc_of[idx] == pc) begin
              r.status = STATUS_OK;
              r.offset = offset_of[idx];
              break;
            end
            idx = (idx + 1) % SLOTS_DEF;
          end
        end
        FUNC_BEGIN: begin
          free_hw = (lim > position) ? lim - position : 0;
          if (occupied > SLOTS_DEF * 3 / 4) begin
            r.status = STATUS_FULL;
          end else if (free_hw < FREE_NEEDED) begin
            r.status = STATUS_LOW;
          end else begin
            pos = position + (position & 1);
            r.status = STATUS_FULL;
            idx = home(pc);
            for (int n = 0; n < SLOTS_DEF; n++) begin
              if (!used[idx] || pc_of[idx] == pc) begin
                if (!used[idx]) begin
                  used[idx]  = 1'b1;
                  pc_of[idx] = pc;
                  occupied++;
                end
                offset_of[idx] = pos[OFS_W-1:0];
                position = pos;
                dirty    = 1'b1;
                r.status = STATUS_OK;
                r.offset = pos[OFS_W-1:0];
                break;
              end
              idx = (idx + 1) % SLOTS_DEF;
            end
          end
        end
        FUNC_ADVANCE: begin
          np = position + 32'(em);
          position = (np < lim) ? np : lim;
        end
        FUNC_FLUSH: begin
          r.flush = dirty;
          dirty   = 1'b0;
        end
        FUNC_RESET: clear_map();
        default: ;
      endcase
      due.push_back(r);
    endfunction

    function void match_result(logic [STATUS_W-1:0] st, logic [OFS_W-1:0] ofs,
                               logic fl);
      map_result_t want;
      if (due.size() == 0) begin
        note_error($sformatf("unexpected beat: status %0d offset 0x%0h flush %0d",
                             st, ofs, fl));
        return;
      end
      want = due.pop_front();
      if (st !== want.status || ofs !== want.offset || fl !== want.flush)
        note_error($sformatf({"mismatch: expected status %0d offset 0x%0h flush %0d,",
                              " got status %0d offset 0x%0h flush %0d"},
                             want.status, want.offset, want.flush, st, ofs, fl));
    endfunction
  endclass

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_W-1:0]      cfg_wdata_i   = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [S_DATA_W-1:0]   s_axis_tdata  = '0;  // guest_pc, emitted_count
  logic [FUNC_W-1:0]     s_axis_tuser  = '0;  // func
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_W-1:0]      m_axis_tdata;        // entry_offset, flush_needed
  logic [STATUS_W-1:0]   m_axis_tuser;        // status

  offset_map_scoreboard  sb = new();
  logic [PC_W-1:0]       known_pcs[$];
  bit                    send_brisk = 1'b0;

  translated_block_map_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  task automatic issue(input logic [FUNC_W-1:0] op, input logic [PC_W-1:0] pc,
                       input logic [EMIT_W-1:0] em);
    int unsigned gap;
    if ($urandom_range(29) == 0) send_brisk = !send_brisk;
    gap = send_brisk ? 0 : $urandom_range(17);
    @(negedge clk_i);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {{(S_DATA_W - PC_W - EMIT_W){1'b0}}, em, pc};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.take_command(op, pc, em);
    if (op == FUNC_BEGIN) known_pcs.push_back(pc);
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_region(input logic [CFG_W-1:0] hw);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= hw;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_region(32'(hw));
  endtask

  function automatic logic [PC_W-1:0] pick_pc(input int unsigned fresh_pct);
    int unsigned r;
    logic [PC_W-1:0] base;
    r = $urandom_range(99);
    if (known_pcs.size() == 0 || r < fresh_pct) return $urandom;
    base = known_pcs[$urandom_range(known_pcs.size() - 1)];
    // same home slot, different pc
    if (r < fresh_pct + (100 - fresh_pct) / 3) return base ^ ($urandom & SAME_HOME_MASK);
    return base;
  endfunction

  task automatic run_mix(input int unsigned count, input int unsigned begin_pct,
                         input int unsigned fresh_pct, input int unsigned emit_max,
                         input bit with_reset);
    int unsigned r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < begin_pct) begin
        issue(FUNC_BEGIN, pick_pc(fresh_pct), EMIT_W'($urandom));
      end else begin
        r = $urandom_range(99);
        if (r < 50)
          issue(FUNC_LOOKUP, pick_pc(30), EMIT_W'($urandom));
        else if (r < 78)
          issue(FUNC_ADVANCE, $urandom, EMIT_W'($urandom_range(emit_max)));
        else if (r < 92 || (r < 96 && !with_reset))
          issue(FUNC_FLUSH, $urandom, EMIT_W'($urandom));
        else if (r < 96)
          issue(FUNC_RESET, $urandom, EMIT_W'($urandom));
        else
          issue(FUNC_W'($urandom_range(FUNC_CODES - 1, FUNC_SPARE_FIRST)), $urandom,
                EMIT_W'($urandom));
      end
    end
  endtask

  initial begin : result_sink
    int unsigned gap;
    int unsigned taken;
    bit brisk;
    taken = 0;
    brisk = 1'b0;
    forever begin
      if ($urandom_range(29) == 0) brisk = !brisk;
      gap = brisk ? 0 : $urandom_range(17);
      if (taken == HOLD_AT) gap = HOLD_CYCLES;
      @(negedge clk_i);
      if (gap != 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      sb.match_result(m_axis_tuser, m_axis_tdata[OFS_W-1:0], m_axis_tdata[OFS_W]);
      taken++;
    end
  end

  initial begin : watchdog
    #150_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    // empty map, pc extremes, odd position padding
    issue(FUNC_LOOKUP, 32'h0000_0000, 12'h000);
    issue(FUNC_LOOKUP, 32'hFFFF_FFFF, 12'hFFF);
    issue(FUNC_BEGIN, 32'h0000_0000, 12'h000);
    issue(FUNC_ADVANCE, 32'h0000_0000, 12'h001);
    issue(FUNC_BEGIN, 32'hFFFF_FFFF, 12'hFFF);
    issue(FUNC_LOOKUP, 32'h0000_0000, 12'h000);
    issue(FUNC_LOOKUP, 32'hFFFF_FFFF, 12'h000);
    // collisions and a probe chain that wraps past the last slot
    issue(FUNC_BEGIN, 32'h0000_0002, 12'h000);
    issue(FUNC_BEGIN, 32'h0000_0802, 12'h000);
    issue(FUNC_BEGIN, 32'h0000_07FE, 12'h000);
    issue(FUNC_BEGIN, 32'h0000_0FFE, 12'h000);
    issue(FUNC_LOOKUP, 32'h0000_0FFE, 12'h000);
    issue(FUNC_LOOKUP, 32'h0000_17FE, 12'h000);
    // retarget an existing entry
    issue(FUNC_ADVANCE, 32'h0000_0000, 12'hFFF);
    issue(FUNC_BEGIN, 32'h0000_0000, 12'h000);
    issue(FUNC_LOOKUP, 32'h0000_0000, 12'h000);
    issue(FUNC_FLUSH, 32'h0000_0000, 12'h000);
    issue(FUNC_FLUSH, 32'h0000_0000, 12'h000);
    for (int k = FUNC_SPARE_FIRST; k < FUNC_CODES; k++)
      issue(FUNC_W'(k), $urandom, EMIT_W'($urandom));
    issue(FUNC_RESET, 32'h0000_0000, 12'h000);
    issue(FUNC_LOOKUP, 32'h0000_0000, 12'h000);
    issue(FUNC_FLUSH, 32'h0000_0000, 12'h000);
    issue(FUNC_ADVANCE, 32'h0000_0000, 12'hFFF);
    wait_idle();

    // smallest region: position past the limit, then exactly enough space
    write_region(CFG_W'(FREE_NEEDED));
    issue(FUNC_BEGIN, 32'h0000_1234, 12'h000);
    issue(FUNC_ADVANCE, 32'h0000_0000, 12'h000);
    issue(FUNC_RESET, 32'h0000_0000, 12'h000);
    issue(FUNC_BEGIN, 32'h0000_1234, 12'h000);
    issue(FUNC_ADVANCE, 32'h0000_0000, 12'h001);
    issue(FUNC_BEGIN, 32'h0000_5678, 12'h000);
    wait_idle();
    write_region('0);
    issue(FUNC_BEGIN, 32'h0000_1234, 12'h000);
    issue(FUNC_LOOKUP, 32'h0000_1234, 12'h000);
    wait_idle();

    // keep beginning new entries well past the table's load limit
    write_region(REGION_MAX);
    issue(FUNC_RESET, $urandom, EMIT_W'($urandom));
    run_mix(1000, 92, 85, 255, 1'b0);
    wait_idle();

    write_region(CFG_W'(4096));
    run_mix(200, 35, 40, 4095, 1'b1);
    wait_idle();

    write_region(CFG_W'(FREE_NEEDED));
    run_mix(100, 35, 40, 4095, 1'b1);
    wait_idle();

    write_region(CFG_W'($urandom_range(CFG_RESET, FREE_NEEDED)));
    run_mix(150, 40, 40, 4095, 1'b1);
    wait_idle();

    write_region(CFG_W'(CFG_RESET));
    run_mix(150, 40, 40, 4095, 1'b1);
    wait_idle();

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.due.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
